@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_SYNC(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked in every cycle including reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/plsc_pkg.sv @@
// Package: sizes, entry layout and state type of the per-layer LRU slot cache.
package plsc_pkg;

  // Table geometry
  localparam int LAYERS = 16;
  localparam int SLOTS  = 64;

  // Fixed field widths
  localparam int LAYER_FW = 4;
  localparam int ID_W     = 6;
  localparam int SLOT_FW  = 6;
  localparam int CAP_W    = 7;
  localparam int CNT_W    = 32;
  localparam int STAMP_W  = 64;

  // Derived widths
  localparam int DEPTH   = LAYERS * SLOTS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W  = $clog2(SLOTS + 1);
  localparam int LIDX_W  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int ENTRY_W = ID_W + STAMP_W;

  // Reset capacity
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Saturation limit of the counters
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/plsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module plsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/per_layer_lru_slot_cache.sv @@
// Top level: per-layer fully associative cache of expert ids with LRU replacement.
//
//   channel  | handshake                     | word
//   ---------+-------------------------------+---------------------------------------
//   in       | in_valid / in_ready           | layer, expert_id
//   out      | out_valid / out_ready         | hit, slot, evicted_valid, evicted_expert,
//            |                               | hit_count, miss_count
//   cfg      | cfg_we (no wait)              | cfg_wdata -> slots_in_use
//
// A lookup reads only the layer's filled slots: the single read port of the entry RAM
// scans one slot per cycle, each entry is compared on its registered read data, and
// the finish step then writes back and loads the output register.
// A finished word sits in the output register; the next word is accepted meanwhile.
// A stalled output holds the write-back step until the register frees.
// rst is synchronous: fill counts, use clock and counters clear, capacity goes to 64;
// the entry RAM needs no clearing since only filled slots are ever read.
module per_layer_lru_slot_cache (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [plsc_pkg::CAP_W-1:0]  cfg_wdata,
  // lookup request
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [plsc_pkg::LAYER_FW-1:0] layer,
  input  logic [plsc_pkg::ID_W-1:0]   expert_id,
  // result
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic [plsc_pkg::SLOT_FW-1:0] slot,
  output logic                        evicted_valid,
  output logic [plsc_pkg::ID_W-1:0]   evicted_expert,
  output logic [plsc_pkg::CNT_W-1:0]  hit_count,
  output logic [plsc_pkg::CNT_W-1:0]  miss_count
);

  // Sequencer
  plsc_pkg::state_t state, state_next;

  // Control state
  logic [plsc_pkg::FILL_W-1:0]   fill_counts [plsc_pkg::LAYERS];
  logic [plsc_pkg::STAMP_W-1:0]  use_clock;
  logic [plsc_pkg::CNT_W-1:0]    hits_total;
  logic [plsc_pkg::CNT_W-1:0]    misses_total;
  logic [plsc_pkg::CAP_W-1:0]    slots_in_use;
  logic [plsc_pkg::FILL_W-1:0]   rd_idx;
  logic [plsc_pkg::FILL_W-1:0]   cmp_idx;
  logic                          rd_pend;
  logic                          found;

  // Request and scan payload
  logic [plsc_pkg::LIDX_W-1:0]   req_layer;
  logic [plsc_pkg::ID_W-1:0]     req_id;
  logic                          req_in_range;
  logic [plsc_pkg::FILL_W-1:0]   req_fill;
  logic [plsc_pkg::SLOT_W-1:0]   match_idx;
  logic [plsc_pkg::STAMP_W-1:0]  min_stamp;
  logic [plsc_pkg::SLOT_W-1:0]   min_idx;
  logic [plsc_pkg::ID_W-1:0]     min_id;

  // Handshake and RAM controls
  logic                          accept;
  logic                          out_free;
  logic                          issue;
  logic                          commit;
  logic                          mem_we;
  logic [plsc_pkg::ADDR_W-1:0]   mem_waddr;
  logic [plsc_pkg::ENTRY_W-1:0]  mem_wdata;
  logic [plsc_pkg::ADDR_W-1:0]   mem_raddr;
  logic [plsc_pkg::ENTRY_W-1:0]  mem_rdata;

  // Decode of a request and of a scanned entry
  logic                          in_range_in;
  logic [plsc_pkg::LIDX_W-1:0]   lidx_in;
  logic [plsc_pkg::ADDR_W-1:0]   row_base;
  logic [plsc_pkg::ID_W-1:0]     ent_id;
  logic [plsc_pkg::STAMP_W-1:0]  ent_stamp;
  logic [plsc_pkg::SLOT_W-1:0]   cmp_slot;

  // Finish-step decisions
  logic [plsc_pkg::FILL_W-1:0]   eff_cap;
  logic                          has_room;
  logic [plsc_pkg::SLOT_W-1:0]   victim;
  logic [plsc_pkg::STAMP_W-1:0]  use_clock_next;
  logic [plsc_pkg::CNT_W-1:0]    hits_total_next;
  logic [plsc_pkg::CNT_W-1:0]    misses_total_next;

  // Entry RAM: {id, stamp} for every layer and slot
  plsc_ram #(
    .WIDTH (plsc_pkg::ENTRY_W),
    .DEPTH (plsc_pkg::DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Request decode
  assign in_range_in = (32'(layer) < plsc_pkg::LAYERS);
  assign lidx_in     = plsc_pkg::LIDX_W'(layer);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;

  // Scan addressing
  assign row_base  = plsc_pkg::ADDR_W'(32'(req_layer) * plsc_pkg::SLOTS);
  assign mem_raddr = row_base + plsc_pkg::ADDR_W'(rd_idx);
  assign ent_id    = mem_rdata[plsc_pkg::ENTRY_W-1:plsc_pkg::STAMP_W];
  assign ent_stamp = mem_rdata[plsc_pkg::STAMP_W-1:0];
  assign cmp_slot  = plsc_pkg::SLOT_W'(cmp_idx);

  // Effective capacity: zero acts as one, above SLOTS acts as SLOTS
  always_comb begin
    if (slots_in_use == '0) begin
      eff_cap = plsc_pkg::FILL_W'(1);
    end else if (32'(slots_in_use) > plsc_pkg::SLOTS) begin
      eff_cap = plsc_pkg::FILL_W'(plsc_pkg::SLOTS);
    end else begin
      eff_cap = plsc_pkg::FILL_W'(slots_in_use);
    end
  end

  // Victim choice and next counter values
  always_comb begin
    has_room          = (req_fill < eff_cap);
    use_clock_next    = use_clock + plsc_pkg::STAMP_W'(1);
    hits_total_next   = (hits_total == plsc_pkg::CNT_MAX) ? hits_total
                                                          : hits_total + 1'b1;
    misses_total_next = (misses_total == plsc_pkg::CNT_MAX) ? misses_total
                                                            : misses_total + 1'b1;
    if (found) begin
      victim = match_idx;
    end else if (has_room) begin
      victim = plsc_pkg::SLOT_W'(req_fill);
    end else begin
      victim = min_idx;
    end
  end

  assign mem_waddr = row_base + plsc_pkg::ADDR_W'(victim);
  assign mem_wdata = {req_id, use_clock_next};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      plsc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = plsc_pkg::ST_SCAN;
        end
      end
      plsc_pkg::ST_SCAN: begin
        if (!issue && !rd_pend) begin
          state_next = plsc_pkg::ST_FINISH;
        end
      end
      plsc_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = plsc_pkg::ST_IDLE;
        end
      end
      default: state_next = plsc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    commit   = 1'b0;
    unique case (state)
      plsc_pkg::ST_IDLE:   in_ready = 1'b1;
      plsc_pkg::ST_SCAN:   issue    = (rd_idx < req_fill);
      plsc_pkg::ST_FINISH: commit   = out_free;
      default: ;
    endcase
    mem_we = commit && req_in_range;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= plsc_pkg::ST_IDLE;
      use_clock    <= '0;
      hits_total   <= '0;
      misses_total <= '0;
      slots_in_use <= plsc_pkg::CAP_RESET;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
      found        <= 1'b0;
      rd_idx       <= '0;
      cmp_idx      <= '0;
      for (int l = 0; l < plsc_pkg::LAYERS; l++) begin
        fill_counts[l] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        slots_in_use <= cfg_wdata;
      end
      // new lookup: restart the scan
      if (accept) begin
        rd_idx  <= '0;
        cmp_idx <= '0;
        rd_pend <= 1'b0;
        found   <= 1'b0;
      end
      // scan: one read issued, one entry compared per cycle
      if (state == plsc_pkg::ST_SCAN) begin
        rd_pend <= issue;
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (rd_pend) begin
          cmp_idx <= cmp_idx + 1'b1;
          if (!found && ent_id == req_id) begin
            found <= 1'b1;
          end
        end
      end
      // write-back and counter update
      if (commit && req_in_range) begin
        use_clock <= use_clock_next;
        if (found) begin
          hits_total <= hits_total_next;
        end else begin
          misses_total <= misses_total_next;
          if (has_room) begin
            fill_counts[req_layer] <= req_fill + 1'b1;
          end
        end
      end
      // output register
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_layer    <= lidx_in;
      req_id       <= expert_id;
      req_in_range <= in_range_in;
      req_fill     <= in_range_in ? fill_counts[lidx_in] : '0;
    end
    // first match, and oldest stamp with lowest index on a tie
    if (state == plsc_pkg::ST_SCAN && rd_pend) begin
      if (!found && ent_id == req_id) begin
        match_idx <= cmp_slot;
      end
      if (cmp_idx == '0 || ent_stamp < min_stamp) begin
        min_stamp <= ent_stamp;
        min_idx   <= cmp_slot;
        min_id    <= ent_id;
      end
    end
    if (commit) begin
      hit            <= req_in_range && found;
      slot           <= req_in_range ? plsc_pkg::SLOT_FW'(victim) : '0;
      evicted_valid  <= req_in_range && !found && !has_room;
      evicted_expert <= (req_in_range && !found && !has_room) ? min_id : '0;
      if (req_in_range && found) begin
        hit_count <= hits_total_next;
      end else begin
        hit_count <= hits_total;
      end
      if (req_in_range && !found) begin
        miss_count <= misses_total_next;
      end else begin
        miss_count <= misses_total;
      end
    end
  end

endmodule

@@ hw/rtl/plsc_checker.sv @@
// Port-level checker for the per-layer LRU slot cache, bound to the top level.
`include "assert_macros.svh"

module plsc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit,
  input logic [plsc_pkg::SLOT_FW-1:0]  slot,
  input logic                          evicted_valid,
  input logic [plsc_pkg::ID_W-1:0]     evicted_expert,
  input logic [plsc_pkg::CNT_W-1:0]    hit_count
);

  // A hit never evicts
  `ASSERT_SYNC(a_hit_no_evict, clk, rst, out_valid |-> !(hit && evicted_valid), "hit with eviction")

  // No eviction reports a zero id
  `ASSERT_SYNC(a_evict_id_zero, clk, rst, (out_valid && !evicted_valid) |-> (evicted_expert == '0), "stale evicted id")

  // A hit word always carries a nonzero hit total
  `ASSERT_SYNC(a_hit_counted, clk, rst, (out_valid && hit) |-> (hit_count != '0), "hit not counted")

  // Stalled word holds
  `ASSERT_SYNC(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(slot) && $stable(hit_count)), "output changed under stall")

  // Nothing leaves right after reset
  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind per_layer_lru_slot_cache plsc_checker u_plsc_checker (.*);
